// ===== rtl/lrast_pkg.sv =====
package lrast_pkg;

   // Default coordinate width, range 8 to 16
   localparam int COORD_BITS_DEF = 12;

   // Packed RGB, eight bits per channel
   localparam int COLOR_BITS = 24;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } lrast_op_type;

   typedef enum logic [1:0] {
      OCT_SHALLOW_RISE = 2'd0,
      OCT_SHALLOW_FALL = 2'd1,
      OCT_STEEP_RISE   = 2'd2,
      OCT_STEEP_FALL   = 2'd3
   } lrast_octant_type;

endpackage

// ===== rtl/lrast_req_if.sv =====
interface lrast_req_if import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   lrast_op_type                 operation;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;
   logic [COLOR_BITS-1:0]        line_color;

   modport source (
      output valid, operation, x_start, y_start, x_end, y_end, line_color,
      input  ready
   );

   modport sink (
      input  valid, operation, x_start, y_start, x_end, y_end, line_color,
      output ready
   );

endinterface

// ===== rtl/lrast_rsp_if.sv =====
interface lrast_rsp_if import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0]        pixel_color;
   logic                         last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_color, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
      output ready
   );

endinterface

// ===== rtl/line_rasterizer_core.sv =====
// Midpoint line rasterizer for all octants. A start transaction on req_chan
// latches two endpoints and a color and produces nothing on rsp_chan; each
// advance transaction then produces one pixel, the last one being the
// right-hand endpoint with last_pixel set, after which further advances
// are dropped until the next start. A start during a running line replaces
// it. The block takes one transaction per clock: req_chan.ready drops only
// while the pixel register holds a pixel that rsp_chan has not taken, and
// a pixel appears in the cycle after its advance. The clock rate is set by
// the per-pixel step, one compare and a three-term add into the decision
// register, and by the start setup (endpoint compare, subtract, magnitude
// compare and decision add).
module line_rasterizer_core import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lrast_req_if.sink   req_chan,
   lrast_rsp_if.source rsp_chan
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int STEP_BITS = COORD_BITS + 2;
   localparam int DEC_BITS  = COORD_BITS + 4;

   localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

   // Line state
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in;
   logic signed [COORD_BITS-1:0] end_y_ff, end_y_in;
   logic signed [DEC_BITS-1:0]   dec_ff, dec_in;
   logic signed [STEP_BITS-1:0]  step_a_ff, step_a_in;
   logic signed [STEP_BITS-1:0]  step_b_ff, step_b_in;
   lrast_octant_type             octant_ff, octant_in;
   logic                         busy_ff, busy_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;

   // Pixel output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic take;
   logic do_start;
   logic do_step;

   // Start setup
   logic                         swap;
   logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
   logic signed [DIFF_BITS-1:0]  dx, dy, abs_dy;
   logic                         shallow;
   logic                         rising;
   logic signed [DEC_BITS-1:0]   dx_w, dy_w;
   lrast_octant_type             new_octant;
   logic signed [DEC_BITS-1:0]   new_dec;

   // Per-pixel step
   logic                         more;
   logic signed [DEC_BITS-1:0]   sa_w, sb_w;
   logic                         dec_pos, dec_neg;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take     = req_chan.valid && req_chan.ready;
   assign do_start = take && (req_chan.operation == OP_START);
   assign do_step  = take && (req_chan.operation == OP_ADVANCE) && busy_ff;

   // Endpoint ordering, slopes and octant choice
   always_comb begin
      swap   = req_chan.x_start > req_chan.x_end;
      xa     = swap ? req_chan.x_end   : req_chan.x_start;
      ya     = swap ? req_chan.y_end   : req_chan.y_start;
      xb     = swap ? req_chan.x_start : req_chan.x_end;
      yb     = swap ? req_chan.y_start : req_chan.y_end;
      dx     = DIFF_BITS'(xb) - DIFF_BITS'(xa);
      dy     = DIFF_BITS'(yb) - DIFF_BITS'(ya);
      abs_dy = dy[DIFF_BITS-1] ? -dy : dy;
      shallow = dx >= abs_dy;
      rising  = (dy > DIFF_BITS'(0));
      dx_w    = DEC_BITS'(dx);
      dy_w    = DEC_BITS'(dy);
      if (shallow) begin
         new_octant = rising ? OCT_SHALLOW_RISE : OCT_SHALLOW_FALL;
      end else begin
         new_octant = rising ? OCT_STEEP_RISE : OCT_STEEP_FALL;
      end
      unique case (new_octant)
         OCT_SHALLOW_RISE: new_dec = dy_w + dy_w - dx_w;
         OCT_SHALLOW_FALL: new_dec = dy_w + dy_w + dx_w;
         OCT_STEEP_RISE:   new_dec = dy_w - dx_w - dx_w;
         OCT_STEEP_FALL:   new_dec = dy_w + dx_w + dx_w;
         default:          new_dec = '0;
      endcase
   end

   // Test for the endpoint along the major axis
   always_comb begin
      unique case (octant_ff)
         OCT_SHALLOW_RISE,
         OCT_SHALLOW_FALL: more = cur_x_ff < end_x_ff;
         OCT_STEEP_RISE:   more = cur_y_ff < end_y_ff;
         OCT_STEEP_FALL:   more = cur_y_ff > end_y_ff;
         default:          more = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      sa_w    = DEC_BITS'(step_a_ff);
      sb_w    = DEC_BITS'(step_b_ff);
      dec_pos = dec_ff > DEC_BITS'(0);
      dec_neg = dec_ff[DEC_BITS-1];

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      dec_in       = dec_ff;
      step_a_in    = step_a_ff;
      step_b_in    = step_b_ff;
      octant_in    = octant_ff;
      busy_in      = busy_ff;
      color_in     = color_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (do_start) begin
         cur_x_in  = xa;
         cur_y_in  = ya;
         end_x_in  = xb;
         end_y_in  = yb;
         step_a_in = STEP_BITS'(dy) <<< 1;
         step_b_in = -(STEP_BITS'(dx) <<< 1);
         octant_in = new_octant;
         dec_in    = new_dec;
         color_in  = req_chan.line_color;
         busy_in   = 1'b1;
      end else if (do_step) begin
         rsp_valid_in = 1'b1;
         if (!more) begin
            // endpoint reached
            rsp_x_in    = end_x_ff;
            rsp_y_in    = end_y_ff;
            rsp_last_in = 1'b1;
            busy_in     = 1'b0;
         end else begin
            rsp_x_in    = cur_x_ff;
            rsp_y_in    = cur_y_ff;
            rsp_last_in = 1'b0;
            unique case (octant_ff)
               OCT_SHALLOW_RISE: begin
                  cur_x_in = cur_x_ff + COORD_ONE;
                  cur_y_in = dec_pos ? cur_y_ff + COORD_ONE : cur_y_ff;
                  dec_in   = dec_ff + (dec_pos ? sb_w : '0) + sa_w;
               end
               OCT_SHALLOW_FALL: begin
                  cur_x_in = cur_x_ff + COORD_ONE;
                  cur_y_in = dec_neg ? cur_y_ff - COORD_ONE : cur_y_ff;
                  dec_in   = dec_ff - (dec_neg ? sb_w : '0) + sa_w;
               end
               OCT_STEEP_RISE: begin
                  cur_y_in = cur_y_ff + COORD_ONE;
                  cur_x_in = dec_neg ? cur_x_ff + COORD_ONE : cur_x_ff;
                  dec_in   = dec_ff + (dec_neg ? sa_w : '0) + sb_w;
               end
               OCT_STEEP_FALL: begin
                  cur_y_in = cur_y_ff - COORD_ONE;
                  cur_x_in = dec_pos ? cur_x_ff + COORD_ONE : cur_x_ff;
                  dec_in   = dec_ff + (dec_pos ? sa_w : '0) - sb_w;
               end
               default: begin
                  dec_in = dec_ff;
               end
            endcase
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      dec_ff      <= dec_in;
      step_a_ff   <= step_a_in;
      step_b_ff   <= step_b_in;
      octant_ff   <= octant_in;
      color_ff    <= color_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = color_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

   // A start always leaves a line in progress
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      do_start |=> busy_ff)
      else $error("line not active after start");

   // Endpoint transaction emits a flagged pixel and ends the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (do_step && !more) |=> (rsp_valid_ff && rsp_last_ff && !busy_ff))
      else $error("endpoint pixel not flagged or line still active");

   // Shallow lines never step past the endpoint in x
   a_shallow_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (octant_ff == OCT_SHALLOW_RISE || octant_ff == OCT_SHALLOW_FALL))
         |-> (cur_x_ff <= end_x_ff))
      else $error("x ran past endpoint");

   // Steep rising lines never step past the endpoint in y
   a_steep_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && octant_ff == OCT_STEEP_RISE) |-> (cur_y_ff <= end_y_ff))
      else $error("y ran past endpoint");

endmodule

// ===== verif/line_rasterizer_checker.sv =====
// Watches both channels of the rasterizer, runs its own midpoint line
// tracer on every accepted request and compares each accepted pixel
// with the oldest pixel still owed.
module line_rasterizer_checker import lrast_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   lrast_req_if req_mon,
   lrast_rsp_if rsp_mon,
   output int   error_count,
   output int   pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS+1:0] step_type;
   typedef logic signed [COORD_BITS+3:0] decision_type;

   typedef struct {
      coord_type             x;
      coord_type             y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   // Tracer state for the line in progress
   coord_type             pos_x, pos_y;
   coord_type             stop_x, stop_y;
   decision_type          err_term;
   step_type              rise_step;   // 2*dy
   step_type              run_step;    // -2*dx
   lrast_octant_type      octant;
   logic                  drawing;
   logic [COLOR_BITS-1:0] ink;

   pixel_type owed_pixels[$];
   int        pixel_index;

   // Latch a new line: order endpoints left to right, pick the octant
   // and seed the decision term.
   task automatic setup_line(input coord_type xs, input coord_type ys, input coord_type xe,
                             input coord_type ye, input logic [COLOR_BITS-1:0] color);
      int xa, ya, xb, yb, dx, dy, ady, seed;
      xa = xs;
      ya = ys;
      xb = xe;
      yb = ye;
      if (xa > xb) begin
         xa = xe;
         ya = ye;
         xb = xs;
         yb = ys;
      end
      dx  = xb - xa;
      dy  = yb - ya;
      ady = (dy < 0) ? -dy : dy;
      if (dx >= ady) begin
         if (dy > 0) begin
            octant = OCT_SHALLOW_RISE;
            seed   = 2 * dy - dx;
         end else begin
            // flat lines and the single point land here too
            octant = OCT_SHALLOW_FALL;
            seed   = 2 * dy + dx;
         end
      end else if (dy > 0) begin
         octant = OCT_STEEP_RISE;
         seed   = dy - 2 * dx;
      end else begin
         octant = OCT_STEEP_FALL;
         seed   = dy + 2 * dx;
      end
      pos_x     = coord_type'(xa);
      pos_y     = coord_type'(ya);
      stop_x    = coord_type'(xb);
      stop_y    = coord_type'(yb);
      rise_step = step_type'(2 * dy);
      run_step  = step_type'(-2 * dx);
      err_term  = decision_type'(seed);
      ink       = color;
      drawing   = 1'b1;
   endtask

   // One advance: owe the current pixel (or the endpoint when done),
   // then take one step along the major axis.
   task automatic step_line();
      logic      more;
      int        err;
      pixel_type px;
      if (drawing) begin
         case (octant)
            OCT_SHALLOW_RISE, OCT_SHALLOW_FALL: more = pos_x < stop_x;
            OCT_STEEP_RISE:                     more = pos_y < stop_y;
            default:                            more = pos_y > stop_y;
         endcase
         px.color = ink;
         if (!more) begin
            px.x    = stop_x;
            px.y    = stop_y;
            px.last = 1'b1;
            drawing = 1'b0;
         end else begin
            px.x    = pos_x;
            px.y    = pos_y;
            px.last = 1'b0;
            err     = err_term;
            case (octant)
               OCT_SHALLOW_RISE: begin
                  if (err > 0) begin
                     pos_y++;
                     err += run_step;
                  end
                  pos_x++;
                  err += rise_step;
               end
               OCT_SHALLOW_FALL: begin
                  if (err < 0) begin
                     pos_y--;
                     err -= run_step;
                  end
                  pos_x++;
                  err += rise_step;
               end
               OCT_STEEP_RISE: begin
                  if (err < 0) begin
                     pos_x++;
                     err += rise_step;
                  end
                  pos_y++;
                  err += run_step;
               end
               default: begin
                  if (err > 0) begin
                     pos_x++;
                     err += rise_step;
                  end
                  pos_y--;
                  err -= run_step;
               end
            endcase
            err_term = decision_type'(err);
         end
         owed_pixels.push_back(px);
      end
   endtask

   task automatic compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: pixel %0d %s mismatch, expected %0d, actual %0d",
                  $time, pixel_index, field, want, got);
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (owed_pixels.size() == 0) begin
         error_count++;
         $display("%0t: pixel %0d unexpected, expected none, actual (%0d,%0d) last=%0b",
                  $time, pixel_index, rsp_mon.pixel_x, rsp_mon.pixel_y,
                  rsp_mon.last_pixel);
      end else begin
         want = owed_pixels.pop_front();
         compare_field("pixel_x", want.x, rsp_mon.pixel_x);
         compare_field("pixel_y", want.y, rsp_mon.pixel_y);
         compare_field("pixel_color", want.color, rsp_mon.pixel_color);
         compare_field("last_pixel", want.last, rsp_mon.last_pixel);
      end
      pixel_index++;
   endtask

   // Sample both channels at the rising edge; a pixel always trails its
   // advance, so checking before predicting is safe.
   always @(posedge clock) begin
      if (reset) begin
         pos_x       = '0;
         pos_y       = '0;
         stop_x      = '0;
         stop_y      = '0;
         err_term    = '0;
         rise_step   = '0;
         run_step    = '0;
         octant      = OCT_SHALLOW_RISE;
         drawing     = 1'b0;
         ink         = '0;
         error_count = 0;
         pixel_index = 0;
         owed_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_pixel();
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == OP_START)
               setup_line(req_mon.x_start, req_mon.y_start, req_mon.x_end,
                          req_mon.y_end, req_mon.line_color);
            else
               step_line();
         end
      end
      pixels_pending = owed_pixels.size();
   end

endmodule

// ===== verif/line_rasterizer_core_tb.sv =====
module line_rasterizer_core_tb import lrast_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB              = COORD_BITS_DEF;
   localparam int ITEM_TARGET     = 1250;
   localparam int IDLE_PCT        = 11;
   localparam int TX_STEADY_FIRST = 600;   // transactions sent without gaps
   localparam int TX_STEADY_LAST  = 1000;
   localparam int HOLD_START      = 300;   // receiver cycles
   localparam int HOLD_CYCLES     = 160;
   localparam int RX_STEADY_FIRST = 800;
   localparam int RX_STEADY_LAST  = 1200;
   localparam int DRAIN_CYCLES    = 10;

   typedef logic signed [CB-1:0]   coord_type;
   typedef logic [COLOR_BITS-1:0]  color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count;
   int   pixels_pending;
   int   items_sent;

   lrast_req_if #(.COORD_BITS(CB)) req_if ();
   lrast_rsp_if #(.COORD_BITS(CB)) rsp_if ();

   line_rasterizer_core #(.COORD_BITS(CB)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   line_rasterizer_checker #(.COORD_BITS(CB)) pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .error_count    (error_count),
      .pixels_pending (pixels_pending)
   );

   always #5 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input lrast_op_type op, input coord_type xs, input coord_type ys,
                            input coord_type xe, input coord_type ye, input color_type color);
      while (!(items_sent >= TX_STEADY_FIRST && items_sent < TX_STEADY_LAST) &&
             $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.operation  <= op;
      req_if.x_start    <= xs;
      req_if.y_start    <= ys;
      req_if.x_end      <= xe;
      req_if.y_end      <= ye;
      req_if.line_color <= color;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Advance with junk in the unused payload fields
   task automatic send_advance();
      send_item(OP_ADVANCE, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), color_type'($urandom));
   endtask

   // Start a line, advance it, then send advances the block should drop.
   task automatic send_line(input int xs, input int ys, input int xe, input int ye,
                            input color_type color, input int advances, input int extra);
      send_item(OP_START, coord_type'(xs), coord_type'(ys), coord_type'(xe),
                coord_type'(ye), color);
      items_sent++;
      repeat (advances) begin
         send_advance();
         items_sent++;
      end
      repeat (extra)
         send_advance();
   endtask

   function automatic int clamp_coord(input int v);
      int lo, hi;
      lo = -(1 << (CB - 1));
      hi = (1 << (CB - 1)) - 1;
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   // Receiver: random stalls, one long hold-off so the block backs up,
   // and a stretch that always takes.
   initial begin
      int rx_cycle;
      rsp_if.ready = 1'b0;
      rx_cycle     = 0;
      forever begin
         @(negedge clock);
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_if.ready <= 1'b0;
         else if (rx_cycle >= RX_STEADY_FIRST && rx_cycle < RX_STEADY_LAST)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
         if (!reset)
            rx_cycle++;
      end
   end

   // Stimulus and verdict
   initial begin
      int xs, ys, xe, ye, reach, shape, mode, span, advances, extra, adx, ady;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_ADVANCE;
      req_if.x_start    = '0;
      req_if.y_start    = '0;
      req_if.x_end      = '0;
      req_if.y_end      = '0;
      req_if.line_color = '0;
      items_sent        = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle advance, single point, octants, swaps, replacement
      send_advance();
      items_sent++;
      send_line(0, 0, 0, 0, 24'h000000, 1, 1);
      send_line(-2048, 2047, -2046, 2047, 24'hFFFFFF, 2, 0);
      send_line(2047, -2048, 2045, -2045, 24'hA5A5A5, 4, 0);
      send_line(0, 0, 3, 1, 24'h5A5A5A, 4, 0);
      send_line(0, 0, -3, 1, 24'h123456, 4, 0);
      send_line(5, 5, 6, 8, 24'hFEDCBA, 1, 0);
      send_line(-2048, -2048, 2047, 2047, 24'h800001, 1, 0);

      // Random lines: mostly short and complete, some cut off, a few huge
      while (items_sent < ITEM_TARGET) begin
         shape = $urandom_range(99);
         xs    = int'(coord_type'($urandom));
         ys    = int'(coord_type'($urandom));
         if (shape < 3) begin
            xe = int'(coord_type'($urandom));
            ye = int'(coord_type'($urandom));
         end else begin
            reach = (shape < 20) ? 40 : 8;
            xe    = clamp_coord(xs + int'($urandom_range(2 * reach)) - reach);
            ye    = clamp_coord(ys + int'($urandom_range(2 * reach)) - reach);
         end
         adx   = (xe > xs) ? xe - xs : xs - xe;
         ady   = (ye > ys) ? ye - ys : ys - ye;
         span  = ((adx > ady) ? adx : ady) + 1;
         mode  = $urandom_range(99);
         extra = (mode >= 92) ? $urandom_range(1, 3) : 0;
         if (shape < 3)
            advances = $urandom_range(40);
         else if (mode < 8)
            advances = $urandom_range(span - 1);
         else
            advances = span;
         send_line(xs, ys, xe, ye, color_type'($urandom), advances, extra);
      end
      req_if.valid <= 1'b0;

      while (pixels_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pixels_pending == 0)
         $display("[line_rasterizer_core] OK");
      else
         $display("[line_rasterizer_core] ERROR");
      $finish;
   end

   // Run limit
   initial begin
      #2ms;
      $display("[line_rasterizer_core] ERROR");
      $finish;
   end

endmodule
